@@ rtl/ocp_pkg.sv @@
// ----------------------------------------------------------------------------
// ocp_pkg - shared constants, codes and helpers of the orbit camera block
// Fixed point angle constants (Q16.16 degrees), CORDIC arctangent table,
// register indexes, action codes and 32 bit saturation.
// ----------------------------------------------------------------------------
package ocp_pkg;

  localparam int MOUSE_BITS_DEF   = 12;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC x/y datapath width, Q2.30 with headroom
  localparam int CS_W = 34;

  localparam logic signed [31:0] DEG_FULL    = 32'sd23592960;
  localparam logic signed [31:0] DEG_HALF    = 32'sd11796480;
  localparam logic signed [31:0] DEG_QUARTER = 32'sd5898240;
  localparam logic signed [31:0] PITCH_LIMIT = 32'sd5522746;

  // 128 full turns, added to make the yaw accumulator positive before reduction
  localparam logic [32:0] YAW_BIAS  = 33'd3019898880;
  localparam int          YAW_STEPS = 8;
  localparam int          YAW_K_W   = $clog2(YAW_STEPS);

  localparam logic [10:0]          ZOOM_STEP = 11'd655;
  localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [15:0] SENS_RESET       = 16'd26;
  localparam logic [30:0] RADIUS_RESET     = 31'd655360;
  localparam logic [30:0] MIN_RADIUS_RESET = 31'd131072;
  localparam logic [30:0] MAX_RADIUS_RESET = 31'd5242880;

  typedef enum logic [2:0] {
    REG_SENSITIVITY = 3'd0,
    REG_TARGET_X    = 3'd1,
    REG_TARGET_Y    = 3'd2,
    REG_TARGET_Z    = 3'd3,
    REG_MIN_RADIUS  = 3'd4,
    REG_MAX_RADIUS  = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ORBIT = 2'd1;
  localparam logic [1:0] ACT_ZOOM  = 2'd2;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ocp_mulq30.sv @@
// ----------------------------------------------------------------------------
// ocp_mulq30 - registered Q2.30 scaling multiplier
// Multiplies two signed operands, rounds half up and drops 30 fraction bits.
// ----------------------------------------------------------------------------
module ocp_mulq30
  import ocp_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [33:0] p
);

  logic signed [65:0] prod;
  logic signed [65:0] rnd;

  assign prod = 66'(a) * 66'(b);
  assign rnd  = prod + (66'sd1 <<< 29);

  always_ff @(posedge clk) begin
    p <= rnd[63:30];
  end

endmodule

@@ rtl/ocp_cordic.sv @@
// ----------------------------------------------------------------------------
// ocp_cordic - iterative sine/cosine unit
// One rotation step per cycle on Q2.30 values, angle in Q16.16 degrees.
// ----------------------------------------------------------------------------
module ocp_cordic
  import ocp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_val,
  output logic signed [31:0] sin_val
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t                 cstate;
  logic [CNT_W-1:0]        cnt;
  logic signed [CS_W-1:0]  x;
  logic signed [CS_W-1:0]  y;
  logic signed [31:0]      z;
  logic                    neg;

  logic signed [CS_W-1:0]  x_sh;
  logic signed [CS_W-1:0]  y_sh;
  logic signed [31:0]      atan;
  logic signed [31:0]      z_init;
  logic                    neg_init;

  assign x_sh = x >>> cnt;
  assign y_sh = y >>> cnt;
  assign atan = atan_deg(5'(cnt));

  // fold into [-90, 90] and flip the result signs
  always_comb begin
    if (angle > DEG_QUARTER) begin
      z_init   = angle - DEG_HALF;
      neg_init = 1'b1;
    end else if (angle < -DEG_QUARTER) begin
      z_init   = angle + DEG_HALF;
      neg_init = 1'b1;
    end else begin
      z_init   = angle;
      neg_init = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      cnt    <= '0;
    end else if (start) begin
      cstate <= C_RUN;
      cnt    <= '0;
      x      <= GAIN_Q30;
      y      <= '0;
      z      <= z_init;
      neg    <= neg_init;
    end else if (cstate == C_RUN) begin
      if (!z[31]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan;
      end
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
        cstate <= C_DONE;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign done    = (cstate == C_DONE);
  assign cos_val = 32'(neg ? -x : x);
  assign sin_val = 32'(neg ? -y : y);

endmodule

@@ rtl/orbit_camera_position_top.sv @@
// The single CORDIC unit runs twice per request (pitch, then yaw).
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register without blocking the next request.
// Reset (rst, synchronous): registers to defaults, radius 10.0, angles and mouse zero.
// ----------------------------------------------------------------------------
// orbit_camera_position_top - orbit camera position from mouse requests
// Tracks yaw, pitch and radius from mouse motion and returns the camera
// position as target plus the spherical offset, all in Q16.16.
// ----------------------------------------------------------------------------
module orbit_camera_position_top
  import ocp_pkg::*;
#(
  parameter int MOUSE_BITS   = MOUSE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MOUSE_BITS-1:0] mouse_x,
  input  logic [MOUSE_BITS-1:0] mouse_y,
  input  logic [1:0]            action,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    pos_z
);

  localparam int DW  = MOUSE_BITS + 1;  // mouse delta
  localparam int OPW = DW + 17;         // delta times sensitivity
  localparam int ZW  = DW + 12;         // (dx - dy) times zoom step

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a request
    S_ACC,    // update yaw, pitch and radius
    S_PREP,   // start pitch CORDIC, bias yaw for reduction
    S_YRED,   // reduce yaw modulo a full turn
    S_WAITP,  // wait pitch sin/cos, then start yaw
    S_WAITY,  // wait yaw sin/cos
    S_MRC,    // r * cos(pitch)
    S_MPY,    // r * sin(pitch)
    S_MPX,    // rc * sin(yaw)
    S_MPZ,    // rc * cos(yaw)
    S_MPW,    // collect z
    S_OUT     // hand the result to the output register
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0]        sensitivity;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic [30:0]        min_radius;
  logic [30:0]        max_radius;

  // camera state
  logic [MOUSE_BITS-1:0] prev_x;
  logic [MOUSE_BITS-1:0] prev_y;
  logic signed [31:0]    yaw_acc;
  logic signed [31:0]    pitch_acc;
  logic [30:0]           orbit_radius;

  // per-request working registers
  logic signed [DW-1:0]  dx;
  logic signed [DW-1:0]  dy;
  logic [1:0]            act;
  logic [32:0]           yred;
  logic [YAW_K_W-1:0]    kcnt;
  logic signed [31:0]    cos_p;
  logic signed [31:0]    sin_p;
  logic signed [31:0]    cos_y;
  logic signed [31:0]    sin_y;
  logic signed [32:0]    rc;
  logic signed [31:0]    px;
  logic signed [31:0]    py;
  logic signed [31:0]    pz;

  // datapath
  logic signed [OPW-1:0] yaw_prod;
  logic signed [OPW-1:0] pitch_prod;
  logic signed [31:0]    yaw_next;
  logic signed [31:0]    pitch_next;
  logic signed [DW:0]    dd;
  logic signed [ZW-1:0]  zoom;
  logic signed [32:0]    rsum;
  logic signed [32:0]    r_hi;
  logic signed [32:0]    r_next;
  logic signed [32:0]    max33;
  logic signed [32:0]    min33;
  logic signed [31:0]    pitch_cl;
  logic [32:0]           yaw_sub;
  logic signed [32:0]    yred_s;
  logic signed [31:0]    yaw_ang;

  // shared units
  logic                  cor_start;
  logic signed [31:0]    cor_angle;
  logic                  cor_done;
  logic signed [31:0]    cor_cos;
  logic signed [31:0]    cor_sin;
  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [33:0]    mul_p;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Orbit: scale the mouse delta by sensitivity (Q8.8) into Q16.16 degrees.
  assign yaw_prod   = OPW'(dx) * OPW'($signed({1'b0, sensitivity}));
  assign pitch_prod = OPW'(dy) * OPW'($signed({1'b0, sensitivity}));
  assign yaw_next   = sat32(48'(yaw_acc) - (48'(yaw_prod) <<< 8));
  assign pitch_next = sat32(48'(pitch_acc) + (48'(pitch_prod) <<< 8));

  // Zoom: radius moves by 0.01 per pixel of (dx - dy).
  assign dd   = (DW + 1)'(dx) - (DW + 1)'(dy);
  assign zoom = ZW'(dd) * ZW'($signed({1'b0, ZOOM_STEP}));
  assign rsum = $signed({2'b00, orbit_radius}) + ((act == ACT_ZOOM) ? 33'(zoom) : 33'sd0);

  // Clamp the radius on every request; the minimum wins if the limits cross.
  assign max33  = $signed({2'b00, max_radius});
  assign min33  = $signed({2'b00, min_radius});
  assign r_hi   = (rsum > max33) ? max33 : rsum;
  assign r_next = (r_hi < min33) ? min33 : r_hi;

  // Keep pitch short of the poles.
  always_comb begin
    if (pitch_acc > PITCH_LIMIT) begin
      pitch_cl = PITCH_LIMIT;
    end else if (pitch_acc < -PITCH_LIMIT) begin
      pitch_cl = -PITCH_LIMIT;
    end else begin
      pitch_cl = pitch_acc;
    end
  end

  // Yaw reduction: compare-subtract of full turns scaled by 2^k, k from 7 down to 0,
  // then shift the result from [0, 360) into [-180, 180).
  assign yaw_sub = 33'(DEG_FULL) << kcnt;
  assign yred_s  = $signed(yred);
  assign yaw_ang = (yred_s >= 33'(DEG_HALF)) ? 32'(yred_s - 33'(DEG_FULL)) : 32'(yred_s);

  // Pitch goes through the CORDIC first, yaw once pitch is done.
  assign cor_start = (state == S_PREP) || ((state == S_WAITP) && cor_done);
  assign cor_angle = (state == S_PREP) ? pitch_cl : yaw_ang;

  ocp_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_val (cor_cos),
    .sin_val (cor_sin)
  );

  // Operand select for the single multiplier; its registered product is read in the next state.
  always_comb begin
    unique case (state)
      S_MRC: begin
        mul_a = $signed({2'b00, orbit_radius});
        mul_b = 33'(cos_p);
      end
      S_MPY: begin
        mul_a = $signed({2'b00, orbit_radius});
        mul_b = 33'(sin_p);
      end
      S_MPX: begin
        mul_a = rc;
        mul_b = 33'(sin_y);
      end
      S_MPZ: begin
        mul_a = rc;
        mul_b = 33'(cos_y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ocp_mulq30 u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sensitivity  <= SENS_RESET;
      target_x     <= '0;
      target_y     <= '0;
      target_z     <= '0;
      min_radius   <= MIN_RADIUS_RESET;
      max_radius   <= MAX_RADIUS_RESET;
      prev_x       <= '0;
      prev_y       <= '0;
      yaw_acc      <= '0;
      pitch_acc    <= '0;
      orbit_radius <= RADIUS_RESET;
      kcnt         <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Register writes; unknown indexes drop.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SENSITIVITY: sensitivity <= cfg_data[15:0];
          REG_TARGET_X:    target_x    <= $signed(cfg_data);
          REG_TARGET_Y:    target_y    <= $signed(cfg_data);
          REG_TARGET_Z:    target_z    <= $signed(cfg_data);
          REG_MIN_RADIUS:  min_radius  <= cfg_data[30:0];
          REG_MAX_RADIUS:  max_radius  <= cfg_data[30:0];
          default: ;
        endcase
      end

      // Load a new result when the output register frees up; otherwise drop
      // the result once the consumer takes it.
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dx     <= $signed({1'b0, mouse_x}) - $signed({1'b0, prev_x});
            dy     <= $signed({1'b0, mouse_y}) - $signed({1'b0, prev_y});
            act    <= action;
            prev_x <= mouse_x;
            prev_y <= mouse_y;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (act == ACT_ORBIT) begin
            yaw_acc   <= yaw_next;
            pitch_acc <= pitch_next;
          end
          orbit_radius <= r_next[30:0];
          state        <= S_PREP;
        end
        S_PREP: begin
          // bias by whole turns so the reduction runs on a positive value
          yred  <= 33'(34'(yaw_acc) + 34'(YAW_BIAS));
          kcnt  <= YAW_K_W'(YAW_STEPS - 1);
          state <= S_YRED;
        end
        S_YRED: begin
          if (yred >= yaw_sub) begin
            yred <= yred - yaw_sub;
          end
          if (kcnt == '0) begin
            state <= S_WAITP;
          end else begin
            kcnt <= kcnt - 1'b1;
          end
        end
        S_WAITP: begin
          if (cor_done) begin
            cos_p <= cor_cos;
            sin_p <= cor_sin;
            state <= S_WAITY;
          end
        end
        S_WAITY: begin
          // done drops the cycle after the yaw start, so this sees yaw only
          if (cor_done) begin
            cos_y <= cor_cos;
            sin_y <= cor_sin;
            state <= S_MRC;
          end
        end
        S_MRC: begin
          state <= S_MPY;
        end
        S_MPY: begin
          rc    <= 33'(mul_p);
          state <= S_MPX;
        end
        S_MPX: begin
          py    <= sat32(48'(target_y) + 48'(mul_p));
          state <= S_MPZ;
        end
        S_MPZ: begin
          px    <= sat32(48'(target_x) + 48'(mul_p));
          state <= S_MPW;
        end
        S_MPW: begin
          pz    <= sat32(48'(target_z) + 48'(mul_p));
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            pos_x     <= px;
            pos_y     <= py;
            pos_z     <= pz;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
